@@ sv/wto_pkg.sv @@
// Shared types, constants and elaboration-time helpers for the wavetable oscillator.
// No dependencies; the other files of the block, apart from wto_ram, import this package.
package wto_pkg;

   // Field widths
   localparam int OPCODE_W    = 2;
   localparam int FREQ_W      = 32;
   localparam int PHASE_W     = 32;
   localparam int TADDR_W     = 16;
   localparam int SAMPLE_W    = 24;
   localparam int STEP_W      = 48;
   localparam int STEP_HALF_W = 24;
   localparam int LEN_W       = 17;
   localparam int OFFSET_W    = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;
   localparam int COS_W       = 21;

   // Opcodes of the request channel
   localparam logic [OPCODE_W-1:0] OP_SAMPLE      = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_WRITE       = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR_PHASE = 2'd2;

   // Register indexes of the CSR port
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SCALE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_USER_TABLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CYCLE_LENGTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_OFFSET    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_POINTS   = 3'd4;

   // Register reset values
   localparam logic [STEP_W-1:0]   STEP_SCALE_RESET   = 48'd23456248059;
   localparam logic [LEN_W-1:0]    CYCLE_LENGTH_RESET = 17'd512;
   localparam logic [OFFSET_W-1:0] READ_OFFSET_RESET  = 16'd0;
   localparam logic [LEN_W-1:0]    TABLE_POINTS_RESET = 17'd0;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // Cosine table generation (Q2.60 Taylor series)
   localparam logic [63:0] PI_Q60       = 64'h3243_F6A8_885A_308D;
   localparam logic [63:0] ONE_Q60      = 64'h1000_0000_0000_0000;
   localparam logic [63:0] ROUND_Q40    = 64'h0000_0080_0000_0000;
   localparam int          ROUND_SHIFT  = 40;
   localparam int          TAYLOR_TERMS = 14;
   localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
      64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
   };

   typedef enum logic [1:0] {
      KIND_SAMPLE,
      KIND_WRITE,
      KIND_CLEAR_PHASE
   } kind_type;

   typedef struct packed {
      kind_type                    kind;
      logic signed [FREQ_W-1:0]    frequency;
      logic [PHASE_W-1:0]          phase_offset;
      logic [TADDR_W-1:0]          table_address;
      logic signed [SAMPLE_W-1:0]  table_value;
   } cmd_type;

   typedef struct packed {
      logic [STEP_W-1:0]   step_scale;
      logic                use_user_table;
      logic [LEN_W-1:0]    cycle_length;
      logic [OFFSET_W-1:0] read_offset;
      logic [LEN_W-1:0]    table_points;
   } cfg_type;

   // Q60 product, bits 60..123 of the full product
   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] full;
      full = 128'(a) * 128'(b);
      return full[123:60];
   endfunction

   // First-quadrant cosine word in Q20, evaluated at elaboration only
   function automatic logic [COS_W-1:0] cos_quarter_word(input logic [63:0] angle);
      logic [63:0] sq;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] rounded;
      sq   = mul_q60(angle, angle);
      term = ONE_Q60;
      sum  = ONE_Q60;
      for (int k = 0; k < TAYLOR_TERMS; k++) begin
         term = mul_q60(term, sq) / TAYLOR_DIV[k];
         if (k[0] == 1'b0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      rounded = (sum + ROUND_Q40) >> ROUND_SHIFT;
      return rounded[COS_W-1:0];
   endfunction

endpackage

@@ sv/wavetable_oscillator_core.sv @@
// Top level of the wavetable oscillator: CSR bank, request front end, execution back end.
// Depends on wto_pkg, wto_front and wto_back (which uses wto_ram and wto_cos_rom).
//
// Phase-accumulator oscillator with linear interpolation. Each sample request adds its
// phase offset to the 32-bit Q0.32 phase, reads two adjacent words (from a cosine ROM
// whose first quadrant is built at elaboration and unfolded by symmetry, or from the
// user wavetable at read_offset plus the scaled index, zero at or past table_points),
// interpolates with FRACTION_BITS of fraction and returns one Q4.20 sample; the phase
// then advances by bits 63..32 of frequency times step_scale. Write requests load a
// table word (addresses at or past TABLE_DEPTH are dropped), clear-phase requests zero
// the phase, and opcode 3 is dropped; none of these returns a response. The front end
// takes one request per cycle, while the queue has room, into a two-entry queue, so
// requests keep flowing while a response waits. The back end works on one request at a
// time: a sample passes from the dequeue through the phase-to-address multiply, the two
// word reads through the single registered read port of the table or ROM, the split step
// multiply and the interpolation multiply, then loads the response register from the done
// state, where it waits while the response register is still full. A table write or phase
// clear completes in the idle state as it is dequeued. Table words never written read back
// undefined. CSRs may be written only while the block is idle.
module wavetable_oscillator_core #(
   parameter int TABLE_DEPTH   = 65536,
   parameter int COS_ROM_SIZE  = 16384,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [wto_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic signed [wto_pkg::FREQ_W-1:0]    req_frequency,
   input  logic [wto_pkg::PHASE_W-1:0]          req_phase_offset,
   input  logic [wto_pkg::TADDR_W-1:0]          req_table_address,
   input  logic signed [wto_pkg::SAMPLE_W-1:0]  req_table_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [wto_pkg::SAMPLE_W-1:0]  rsp_sample,
   input  logic                                 csr_write_en,
   input  logic [wto_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [wto_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import wto_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   // CSR bank: update the addressed register, ignore unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_STEP_SCALE:     cfg_in.step_scale     = csr_wdata[STEP_W-1:0];
            CSR_USE_USER_TABLE: cfg_in.use_user_table = csr_wdata[0];
            CSR_CYCLE_LENGTH:   cfg_in.cycle_length   = csr_wdata[LEN_W-1:0];
            CSR_READ_OFFSET:    cfg_in.read_offset    = csr_wdata[OFFSET_W-1:0];
            CSR_TABLE_POINTS:   cfg_in.table_points   = csr_wdata[LEN_W-1:0];
            default: begin
               // no register at this index
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_scale     <= STEP_SCALE_RESET;
         cfg_ff.use_user_table <= 1'b0;
         cfg_ff.cycle_length   <= CYCLE_LENGTH_RESET;
         cfg_ff.read_offset    <= READ_OFFSET_RESET;
         cfg_ff.table_points   <= TABLE_POINTS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accept, classify and queue requests
   wto_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_frequency     (req_frequency),
      .req_phase_offset  (req_phase_offset),
      .req_table_address (req_table_address),
      .req_table_value   (req_table_value),
      .cmd_valid         (cmd_valid),
      .cmd_ready         (cmd_ready),
      .cmd               (cmd)
   );

   // Back end: run queued requests and drive the response register
   wto_back #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .COS_ROM_SIZE  (COS_ROM_SIZE),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .cfg        (cfg_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (rsp_sample)
   );
endmodule

@@ sv/wto_ram.sv @@
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
module wto_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ sv/wto_cos_rom.sv @@
// First-quadrant cosine ROM with registered read; contents built at elaboration.
// Depends on wto_pkg (cos_quarter_word, PI_Q60, COS_W).
module wto_cos_rom #(
   parameter int COS_ROM_SIZE = 16384
) (
   input  logic                              clock,
   input  logic [$clog2(COS_ROM_SIZE/4)-1:0] rd_addr,
   output logic [wto_pkg::COS_W-1:0]         rd_data
);
   import wto_pkg::*;

   localparam int          QUARTER = COS_ROM_SIZE / 4;
   localparam logic [63:0] PI_STEP = PI_Q60 / COS_ROM_SIZE;
   localparam logic [63:0] PI_REM  = PI_Q60 % COS_ROM_SIZE;

   logic [COS_W-1:0] words [QUARTER];
   logic [COS_W-1:0] rd_data_ff;

   for (genvar i = 0; i < QUARTER; i++) begin : g_word
      localparam logic [63:0] ANGLE =
         PI_STEP * 64'(2 * i) + (PI_REM * 64'(2 * i)) / COS_ROM_SIZE;
      localparam logic [COS_W-1:0] WORD = cos_quarter_word(ANGLE);
      assign words[i] = WORD;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= words[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ sv/wto_front.sv @@
// Request front end: accepts requests, drops those with no effect, queues the rest.
// Depends on wto_pkg (cmd_type, opcodes, queue sizing).
module wto_front #(
   parameter int TABLE_DEPTH = 65536
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [wto_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic signed [wto_pkg::FREQ_W-1:0]    req_frequency,
   input  logic [wto_pkg::PHASE_W-1:0]          req_phase_offset,
   input  logic [wto_pkg::TADDR_W-1:0]          req_table_address,
   input  logic signed [wto_pkg::SAMPLE_W-1:0]  req_table_value,
   output logic                                 cmd_valid,
   input  logic                                 cmd_ready,
   output wto_pkg::cmd_type                     cmd
);
   import wto_pkg::*;

   cmd_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0]  count_ff, count_in;
   cmd_type              incoming;
   logic                 keep;
   logic                 push;
   logic                 pop;

   // Classify: drop unknown opcodes and table writes past the end
   always_comb begin
      incoming.kind          = KIND_SAMPLE;
      incoming.frequency     = req_frequency;
      incoming.phase_offset  = req_phase_offset;
      incoming.table_address = req_table_address;
      incoming.table_value   = req_table_value;
      keep                   = 1'b0;
      unique case (req_opcode)
         OP_SAMPLE: begin
            incoming.kind = KIND_SAMPLE;
            keep          = 1'b1;
         end
         OP_WRITE: begin
            incoming.kind = KIND_WRITE;
            keep          = 32'(req_table_address) < 32'(TABLE_DEPTH);
         end
         OP_CLEAR_PHASE: begin
            incoming.kind = KIND_CLEAR_PHASE;
            keep          = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = count_ff != QCOUNT_W'(QUEUE_DEPTH);
   assign push      = req_valid && req_ready && keep;
   assign cmd_valid = count_ff != '0;
   assign cmd       = queue_ff[rd_ptr_ff];
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCOUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= incoming;
      end
   end
endmodule

@@ sv/wto_back.sv @@
// Execution back end: phase accumulator, table/ROM lookup, interpolation, result register.
// Depends on wto_pkg, wto_ram and wto_cos_rom.
module wto_back #(
   parameter int TABLE_DEPTH   = 65536,
   parameter int COS_ROM_SIZE  = 16384,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_valid,
   output logic                                 cmd_ready,
   input  wto_pkg::cmd_type                     cmd,
   input  wto_pkg::cfg_type                     cfg,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [wto_pkg::SAMPLE_W-1:0]  rsp_sample
);
   import wto_pkg::*;

   localparam int ADDR_W   = $clog2(TABLE_DEPTH);
   localparam int QUARTER  = COS_ROM_SIZE / 4;
   localparam int QADDR_W  = $clog2(QUARTER);
   localparam int POS_W    = PHASE_W + LEN_W;
   localparam int UADDR_W  = TADDR_W + 2;
   localparam int DIFF_W   = SAMPLE_W + 1;
   localparam int PROD_W   = DIFF_W + FRACTION_BITS + 1;
   localparam int INTERP_W = SAMPLE_W + 2;
   localparam int PP_W     = FREQ_W + STEP_HALF_W + 1;
   localparam logic [LEN_W-1:0] ROM_LEN     = LEN_W'(COS_ROM_SIZE);
   localparam logic [LEN_W-1:0] ROM_HALF    = LEN_W'(COS_ROM_SIZE / 2);
   localparam logic [LEN_W-1:0] ROM_QUARTER = LEN_W'(QUARTER);
   localparam logic signed [PROD_W-1:0] ROUND_HALF =
      PROD_W'(1) <<< (FRACTION_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_READ_A,
      ST_READ_B,
      ST_FETCH_B,
      ST_INTERP,
      ST_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic [PHASE_W-1:0]          phase_ff, phase_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  rsp_sample_ff, rsp_sample_in;
   logic [PHASE_W-1:0]          w_ff, w_in;
   logic signed [FREQ_W-1:0]    freq_ff, freq_in;
   logic [POS_W-1:0]            pos_ff, pos_in;
   logic                        flag_zero_ff, flag_zero_in;
   logic                        flag_neg_ff, flag_neg_in;
   logic signed [SAMPLE_W-1:0]  a_ff, a_in;
   logic signed [SAMPLE_W-1:0]  b_ff, b_in;
   logic signed [PP_W-1:0]      pp_lo_ff, pp_lo_in;
   logic signed [PP_W-1:0]      pp_hi_ff, pp_hi_in;
   logic [PHASE_W-1:0]          step_ff, step_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;

   logic                        ram_we;
   logic [ADDR_W-1:0]           ram_waddr;
   logic [ADDR_W-1:0]           ram_raddr;
   logic [SAMPLE_W-1:0]         ram_rdata;
   logic [QADDR_W-1:0]          rom_addr;
   logic [COS_W-1:0]            rom_rdata;

   logic                        second;
   logic [LEN_W-1:0]            idx;
   logic [FRACTION_BITS-1:0]    frac;
   logic [LEN_W-1:0]            len;
   logic [UADDR_W-1:0]          uaddr;
   logic                        u_in_range;
   logic [LEN_W-1:0]            cidx;
   logic [LEN_W-1:0]            fold;
   logic [LEN_W-1:0]            qaddr;
   logic                        c_zero;
   logic                        c_neg;
   logic                        rd_zero;
   logic                        rd_neg;
   logic signed [SAMPLE_W-1:0]  rom_word;
   logic signed [SAMPLE_W-1:0]  rd_word;
   logic signed [DIFF_W-1:0]    diff;
   logic [63:0]                 step_full;
   logic signed [PROD_W-1:0]    biased;
   logic signed [PROD_W-1:0]    shifted;
   logic signed [INTERP_W-1:0]  y_full;
   logic                        out_free;

   // Lookup position: integer index above the phase bits, fraction below
   assign len    = cfg.use_user_table ? cfg.cycle_length : ROM_LEN;
   assign idx    = pos_ff[POS_W-1:PHASE_W];
   assign frac   = pos_ff[PHASE_W-1 -: FRACTION_BITS];
   assign second = (state_ff == ST_READ_B);

   // User table address; out of range reads as zero
   assign uaddr = UADDR_W'(cfg.read_offset) + UADDR_W'(idx) + UADDR_W'(second);
   assign u_in_range = (uaddr < UADDR_W'(cfg.table_points))
                    && (32'(uaddr) < 32'(TABLE_DEPTH));
   assign ram_raddr = ADDR_W'(uaddr);

   // Fold the full-cycle index onto the first quadrant
   assign cidx   = idx + LEN_W'(second);
   assign fold   = (cidx <= ROM_HALF) ? cidx : ROM_LEN - cidx;
   assign c_zero = (fold == ROM_QUARTER);
   assign c_neg  = (fold > ROM_QUARTER);
   assign qaddr  = c_neg ? ROM_HALF - fold : fold;
   assign rom_addr = qaddr[QADDR_W-1:0];

   assign rd_zero = cfg.use_user_table ? !u_in_range : c_zero;
   assign rd_neg  = !cfg.use_user_table && c_neg;

   // Word returned by the registered read issued in the state before
   assign rom_word = {{(SAMPLE_W - COS_W){1'b0}}, rom_rdata};
   always_comb begin
      if (flag_zero_ff) begin
         rd_word = '0;
      end else if (cfg.use_user_table) begin
         rd_word = ram_rdata;
      end else if (flag_neg_ff) begin
         rd_word = -rom_word;
      end else begin
         rd_word = rom_word;
      end
   end

   assign diff      = $signed({b_ff[SAMPLE_W-1], b_ff}) - $signed({a_ff[SAMPLE_W-1], a_ff});
   assign step_full = 64'(pp_lo_ff) + (64'(pp_hi_ff) << STEP_HALF_W);
   assign biased    = prod_ff + ROUND_HALF;
   assign shifted   = biased >>> FRACTION_BITS;
   assign y_full    = $signed({{2{a_ff[SAMPLE_W-1]}}, a_ff}) + shifted[INTERP_W-1:0];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign ram_we    = (state_ff == ST_IDLE) && cmd_valid && (cmd.kind == KIND_WRITE);
   assign ram_waddr = ADDR_W'(cmd.table_address);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      w_in          = w_ff;
      freq_in       = freq_ff;
      pos_in        = pos_ff;
      flag_zero_in  = flag_zero_ff;
      flag_neg_in   = flag_neg_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      pp_lo_in      = pp_lo_ff;
      pp_hi_in      = pp_hi_ff;
      step_in       = step_ff;
      prod_in       = prod_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  KIND_SAMPLE: begin
                     w_in     = phase_ff + cmd.phase_offset;
                     freq_in  = cmd.frequency;
                     state_in = ST_SCALE;
                  end
                  KIND_CLEAR_PHASE: begin
                     phase_in = '0;
                  end
                  default: begin
                     // table write goes straight to the RAM port
                  end
               endcase
            end
         end
         ST_SCALE: begin
            pos_in   = POS_W'(w_ff) * POS_W'(len);
            state_in = ST_READ_A;
         end
         ST_READ_A: begin
            flag_zero_in = rd_zero;
            flag_neg_in  = rd_neg;
            pp_lo_in     = PP_W'(freq_ff)
                         * PP_W'($signed({1'b0, cfg.step_scale[STEP_HALF_W-1:0]}));
            state_in     = ST_READ_B;
         end
         ST_READ_B: begin
            a_in         = rd_word;
            flag_zero_in = rd_zero;
            flag_neg_in  = rd_neg;
            pp_hi_in     = PP_W'(freq_ff)
                         * PP_W'($signed({1'b0, cfg.step_scale[STEP_W-1:STEP_HALF_W]}));
            state_in     = ST_FETCH_B;
         end
         ST_FETCH_B: begin
            b_in     = rd_word;
            step_in  = step_full[63:32];
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            prod_in  = PROD_W'(diff) * PROD_W'($signed({1'b0, frac}));
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register frees up
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = y_full[SAMPLE_W-1:0];
               phase_in      = phase_ff + step_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sample_ff <= rsp_sample_in;
      w_ff          <= w_in;
      freq_ff       <= freq_in;
      pos_ff        <= pos_in;
      flag_zero_ff  <= flag_zero_in;
      flag_neg_ff   <= flag_neg_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      pp_lo_ff      <= pp_lo_in;
      pp_hi_ff      <= pp_hi_in;
      step_ff       <= step_in;
      prod_ff       <= prod_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   wto_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (cmd.table_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   wto_cos_rom #(
      .COS_ROM_SIZE (COS_ROM_SIZE)
   ) u_cos (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_rdata)
   );
endmodule

@@ sim/osc_sample_checker.sv @@
`timescale 1ns / 100ps
// Sample checker for wavetable_oscillator_core: watches CSR writes, requests and responses,
// predicts every sample from its own oscillator state and compares. Depends on wto_pkg.
module osc_sample_checker #(
   parameter int TABLE_WORDS = 65536,
   parameter int COS_WORDS   = 16384,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [wto_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic signed [wto_pkg::FREQ_W-1:0]    req_frequency,
   input  logic [wto_pkg::PHASE_W-1:0]          req_phase_offset,
   input  logic [wto_pkg::TADDR_W-1:0]          req_table_address,
   input  logic signed [wto_pkg::SAMPLE_W-1:0]  req_table_value,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [wto_pkg::SAMPLE_W-1:0]  rsp_sample,
   input  logic                                 csr_write_en,
   input  logic [wto_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [wto_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output int                                   failures,
   output int                                   outstanding
);
   import wto_pkg::*;

   localparam logic [63:0] PI_FX60       = 64'h3243_F6A8_885A_308D;
   localparam logic [63:0] ONE_FX60      = 64'h1000_0000_0000_0000;
   localparam logic [63:0] HALF_LSB_FX40 = 64'h0000_0080_0000_0000;
   localparam int          SERIES_TERMS  = 14;

   int                          cos_words [0:COS_WORDS];
   logic [SAMPLE_W-1:0]         user_words [0:TABLE_WORDS-1];
   logic [STEP_W-1:0]           step_scale;
   logic                        use_user_table;
   logic [LEN_W-1:0]            cycle_length;
   logic [OFFSET_W-1:0]         read_offset;
   logic [LEN_W-1:0]            table_points;
   logic [PHASE_W-1:0]          phase;
   logic signed [SAMPLE_W-1:0]  expected_samples [$];

   // Bits 60..123 of the 128-bit product of two Q2.60 values
   function automatic logic [63:0] fx60_mul(input logic [63:0] x, input logic [63:0] y);
      logic [127:0] wide;
      wide = {64'd0, x} * {64'd0, y};
      return wide[123:60];
   endfunction

   // First-quadrant cosine in Q20 from a Taylor series at Q2.60
   function automatic int quadrant_cos(input int unsigned i);
      logic [63:0] coarse, remain, twice, angle, angle_sq, term, acc, rounded;
      coarse   = PI_FX60 / COS_WORDS;
      remain   = PI_FX60 % COS_WORDS;
      twice    = 64'(i) * 2;
      angle    = coarse * twice + (remain * twice) / COS_WORDS;
      angle_sq = fx60_mul(angle, angle);
      term     = ONE_FX60;
      acc      = ONE_FX60;
      for (int k = 1; k <= SERIES_TERMS; k++) begin
         term = fx60_mul(term, angle_sq) / 64'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      rounded = (acc + HALF_LSB_FX40) >> 40;
      return int'(rounded[31:0]);
   endfunction

   // Words at or past the loaded length read as zero
   function automatic longint user_word(input logic [63:0] addr);
      if (addr >= 64'(table_points) || addr >= TABLE_WORDS) begin
         return 0;
      end
      return longint'(signed'(user_words[addr]));
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sample_at(input logic [PHASE_W-1:0] where);
      logic [63:0]          span, scaled, base;
      logic [FRAC_BITS-1:0] frac;
      longint               lo_word, hi_word, prod, y;
      span   = use_user_table ? 64'(cycle_length) : 64'(COS_WORDS);
      scaled = 64'(where) * span;
      base   = scaled >> 32;
      frac   = scaled[31 -: FRAC_BITS];
      if (use_user_table) begin
         lo_word = user_word(64'(read_offset) + base);
         hi_word = user_word(64'(read_offset) + base + 64'd1);
      end else begin
         lo_word = cos_words[base];
         hi_word = cos_words[base + 1];
      end
      // round half up, floor division by the fraction scale
      prod = (hi_word - lo_word) * longint'({1'b0, frac}) + (longint'(1) <<< (FRAC_BITS - 1));
      y    = lo_word + (prod >>> FRAC_BITS);
      return y[SAMPLE_W-1:0];
   endfunction

   function automatic logic [PHASE_W-1:0] phase_step(input logic [FREQ_W-1:0] freq);
      logic [63:0] prod;
      prod = {{(64 - FREQ_W){freq[FREQ_W-1]}}, freq} * {{(64 - STEP_W){1'b0}}, step_scale};
      return prod[63:32];
   endfunction

   initial begin
      int quarter;
      failures    = 0;
      outstanding = 0;
      quarter     = COS_WORDS / 4;
      for (int i = 0; i < quarter; i++) begin
         cos_words[i] = quadrant_cos(i);
      end
      cos_words[quarter] = 0;
      for (int j = 0; j < quarter; j++) begin
         cos_words[quarter + 1 + j] = -cos_words[quarter - 1 - j];
      end
      for (int j = 0; j < 2 * quarter; j++) begin
         cos_words[2 * quarter + 1 + j] = cos_words[2 * quarter - 1 - j];
      end
   end

   always @(posedge clock) begin
      logic signed [SAMPLE_W-1:0] want;
      if (reset) begin
         step_scale     = STEP_SCALE_RESET;
         use_user_table = 1'b0;
         cycle_length   = CYCLE_LENGTH_RESET;
         read_offset    = READ_OFFSET_RESET;
         table_points   = TABLE_POINTS_RESET;
         phase          = '0;
         expected_samples.delete();
         outstanding <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_STEP_SCALE:     step_scale     = csr_wdata[STEP_W-1:0];
               CSR_USE_USER_TABLE: use_user_table = csr_wdata[0];
               CSR_CYCLE_LENGTH:   cycle_length   = csr_wdata[LEN_W-1:0];
               CSR_READ_OFFSET:    read_offset    = csr_wdata[OFFSET_W-1:0];
               CSR_TABLE_POINTS:   table_points   = csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected response, expected none, got sample %0d",
                        $time, rsp_sample);
               failures <= failures + 1;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample !== want) begin
                  $display("%0t: sample mismatch, expected %0d, got %0d",
                           $time, want, rsp_sample);
                  failures <= failures + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_opcode)
               OP_SAMPLE: begin
                  expected_samples.push_back(sample_at(phase + req_phase_offset));
                  phase = phase + phase_step(req_frequency);
               end
               OP_WRITE:       user_words[req_table_address] = req_table_value;
               OP_CLEAR_PHASE: phase = '0;
               default: ;
            endcase
         end
         outstanding <= expected_samples.size();
      end
   end

endmodule

@@ sim/wavetable_oscillator_core_tb.sv @@
`timescale 1ns / 100ps
// Top of the wavetable_oscillator_core testbench: clock, reset, CSR and request stimulus,
// response back-pressure and the verdict. Depends on wto_pkg and osc_sample_checker.
module wavetable_oscillator_core_tb;
   import wto_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;   // dropped by the block
   localparam int TABLE_WORDS     = 65536;
   localparam int MAX_GAP         = 19;
   localparam int SETTLE_CYCLES   = 16;     // queue plus one back-end pass, with margin
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_ITEMS    = 1500;
   localparam int MAX_LOAD        = 48;     // most table words a setting may need loaded
   localparam int CYCLE_LIMIT     = 1000000;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [OPCODE_W-1:0]          req_opcode;
   logic signed [FREQ_W-1:0]     req_frequency;
   logic [PHASE_W-1:0]           req_phase_offset;
   logic [TADDR_W-1:0]           req_table_address;
   logic signed [SAMPLE_W-1:0]   req_table_value;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [SAMPLE_W-1:0]   rsp_sample;
   logic                         csr_write_en;
   logic [CSR_INDEX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]        csr_wdata;

   int  failures;
   int  outstanding;
   int  cycle_count = 0;
   int  random_items = 0;       // every request sent so far
   bit  loaded [TABLE_WORDS];   // table words written so far; others are never read
   bit  no_idle = 1'b0;         // stretch with no gaps on either side
   bit  hold_off = 1'b0;        // ask the receiver for one long stall

   // Current register settings, kept to plan which table words get read
   int  plan_cycle_length;
   int  plan_read_offset;
   int  plan_table_points;

   wavetable_oscillator_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_frequency     (req_frequency),
      .req_phase_offset  (req_phase_offset),
      .req_table_address (req_table_address),
      .req_table_value   (req_table_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample        (rsp_sample),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   osc_sample_checker sample_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_frequency     (req_frequency),
      .req_phase_offset  (req_phase_offset),
      .req_table_address (req_table_address),
      .req_table_value   (req_table_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample        (rsp_sample),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .failures          (failures),
      .outstanding       (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: well past the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("wavetable_oscillator_core_tb failed");
         $finish;
      end
   end

   // Receiver: draw a stall per response, or hold off for a long stretch on request.
   // Ready then stays high until the response is taken.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off = 1'b0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
               rsp_ready = 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_ready = 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Offer one request after a random gap; hold valid and payload until accepted.
   // Returns right after the accepting edge.
   task automatic send_request(input logic [OPCODE_W-1:0] op,
                               input logic [FREQ_W-1:0]   freq,
                               input logic [PHASE_W-1:0]  offset,
                               input logic [TADDR_W-1:0]  addr,
                               input logic [SAMPLE_W-1:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode        = op;
      req_frequency     = freq;
      req_phase_offset  = offset;
      req_table_address = addr;
      req_table_value   = value;
      req_valid         = 1'b1;
      if (op == OP_WRITE) begin
         loaded[addr] = 1'b1;
      end
      random_items++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait until every sample is back, then let writes and clears drain
   task automatic settle_block();
      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0]  data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = index;
      csr_wdata    = data;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic write_settings(input logic [STEP_W-1:0] step, input bit user,
                                 input int length, input int offset, input int points);
      write_csr(CSR_STEP_SCALE, CSR_DATA_W'(step));
      write_csr(CSR_USE_USER_TABLE, CSR_DATA_W'(user));
      write_csr(CSR_CYCLE_LENGTH, CSR_DATA_W'(length));
      write_csr(CSR_READ_OFFSET, CSR_DATA_W'(offset));
      write_csr(CSR_TABLE_POINTS, CSR_DATA_W'(points));
      plan_cycle_length = length;
      plan_read_offset  = offset;
      plan_table_points = points;
   endtask

   // Highest in-range word a user-table read can touch: offset .. offset + length
   // (offset + 1 when the cycle length is zero), cut at the loaded length and the depth
   function automatic int last_read_word(input int offset, input int length, input int points);
      int top;
      top = offset + ((length == 0) ? 1 : length);
      if (top > points - 1) top = points - 1;
      if (top > TABLE_WORDS - 1) top = TABLE_WORDS - 1;
      return top;
   endfunction

   // Load every word the current settings can read that was never written
   task automatic load_cycle_words();
      int top;
      top = last_read_word(plan_read_offset, plan_cycle_length, plan_table_points);
      for (int a = plan_read_offset; a <= top; a++) begin
         if (!loaded[a]) begin
            send_request(OP_WRITE, $urandom, $urandom, a[TADDR_W-1:0],
                         SAMPLE_W'($urandom));
         end
      end
   endtask

   task automatic pick_settings();
      logic [STEP_W-1:0] step;
      int                length;
      int                offset;
      int                points;
      case ($urandom_range(0, 4))
         0:       step = STEP_SCALE_RESET;
         1:       step = '0;
         2:       step = '1;
         3:       step = STEP_W'($urandom_range(1, 1 << 24));
         default: step = STEP_W'({$urandom, $urandom});
      endcase
      case ($urandom_range(0, 6))
         0:       length = 0;
         1:       length = 1;
         2:       length = TABLE_WORDS;
         3:       length = 512;
         4, 5:    length = $urandom_range(2, MAX_LOAD);
         default: length = $urandom_range(1, TABLE_WORDS);
      endcase
      case ($urandom_range(0, 3))
         0:       offset = 0;
         1:       offset = TABLE_WORDS - 1;
         default: offset = $urandom_range(0, TABLE_WORDS - 1);
      endcase
      case ($urandom_range(0, 3))
         0:       points = 0;
         1:       points = TABLE_WORDS;
         2:       points = offset + $urandom_range(0, MAX_LOAD);
         default: points = $urandom_range(0, TABLE_WORDS);
      endcase
      if (points > TABLE_WORDS) points = TABLE_WORDS;
      // keep the set of readable words small enough to load
      if (last_read_word(offset, length, points) - offset + 1 > MAX_LOAD) begin
         if ($urandom_range(0, 1) == 0) begin
            points = offset + $urandom_range(1, MAX_LOAD);
            if (points > TABLE_WORDS) points = TABLE_WORDS;
         end else begin
            offset = TABLE_WORDS - $urandom_range(1, MAX_LOAD);
         end
      end
      write_settings(step, 1'($urandom_range(0, 1)), length, offset, points);
   endtask

   // One random request, mostly samples, with extremes mixed into the frequency and phase offset
   task automatic random_request();
      int                  pick;
      int                  near;
      logic [OPCODE_W-1:0] op;
      logic [FREQ_W-1:0]   freq;
      logic [PHASE_W-1:0]  offset;
      logic [TADDR_W-1:0]  addr;
      pick = $urandom_range(0, 99);
      if (pick < 75) op = OP_SAMPLE;
      else if (pick < 87) op = OP_WRITE;
      else if (pick < 95) op = OP_CLEAR_PHASE;
      else op = OP_UNUSED;
      case ($urandom_range(0, 5))
         0:       freq = '0;
         1:       freq = 32'h7FFF_FFFF;
         2:       freq = 32'h8000_0000;
         3, 4: begin
            near = int'($urandom_range(0, 1 << 17)) - (1 << 16);
            freq = near;
         end
         default: freq = $urandom;
      endcase
      case ($urandom_range(0, 4))
         0, 1:    offset = '0;
         2:       offset = '1;
         default: offset = $urandom;
      endcase
      // aim half the writes at the words the current cycle reads
      if ($urandom_range(0, 1) == 0) begin
         near = plan_read_offset + $urandom_range(0, plan_cycle_length);
         addr = near[TADDR_W-1:0];
      end else begin
         addr = TADDR_W'($urandom);
      end
      send_request(op, freq, offset, addr, SAMPLE_W'($urandom));
   endtask

   initial begin
      int phase_index;
      int items;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_opcode        = OP_SAMPLE;
      req_frequency     = '0;
      req_phase_offset  = '0;
      req_table_address = '0;
      req_table_value   = '0;
      csr_write_en      = 1'b0;
      csr_index         = CSR_STEP_SCALE;
      csr_wdata         = '0;
      plan_cycle_length = int'(CYCLE_LENGTH_RESET);
      plan_read_offset  = int'(READ_OFFSET_RESET);
      plan_table_points = int'(TABLE_POINTS_RESET);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Cosine ROM at reset settings: start, end of cycle, quarter, half, both
      // frequency extremes, backwards motion and a phase clear
      send_request(OP_SAMPLE, 32'h0000_0000, 32'h0000_0000, '0, '0);
      send_request(OP_SAMPLE, 32'h0000_0000, 32'hFFFF_FFFF, '0, '0);
      send_request(OP_SAMPLE, 32'h7FFF_FFFF, 32'h4000_0000, '0, '0);
      send_request(OP_SAMPLE, 32'h8000_0000, 32'h8000_0000, '0, '0);
      send_request(OP_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0000, '0, '0);
      send_request(OP_CLEAR_PHASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1);
      send_request(OP_SAMPLE, 32'h0000_4000, 32'hC000_0000, '0, '0);
      // unknown opcode, all fields high: must leave no trace
      send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1);
      // table words at both ends with extreme values
      send_request(OP_WRITE, '0, '0, 16'h0000, 24'h80_0000);
      send_request(OP_WRITE, '0, '0, 16'hFFFF, 24'h7F_FFFF);
      send_request(OP_WRITE, '0, '0, 16'h0001, 24'h00_0000);

      // Zero cycle length: every sample is the word at the read offset
      settle_block();
      write_settings(STEP_SCALE_RESET, 1'b1, 0, 0, 2);
      send_request(OP_SAMPLE, 32'h0001_2345, $urandom, '0, '0);
      send_request(OP_SAMPLE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '0, '0);

      // Longest cycle at the last word: the upper neighbor is past the table depth
      settle_block();
      write_settings('1, 1'b1, TABLE_WORDS, TABLE_WORDS - 1, TABLE_WORDS);
      send_request(OP_SAMPLE, 32'h7FFF_FFFF, 32'h0000_0000, '0, '0);
      send_request(OP_SAMPLE, 32'h8000_0000, 32'hFFFF_FFFF, '0, '0);
      send_request(OP_SAMPLE, 32'h0000_0000, 32'h8000_0000, '0, '0);

      // Short cycle running past the loaded length: upper words read as zero
      settle_block();
      write_settings(STEP_SCALE_RESET, 1'b1, 4, 100, 102);
      send_request(OP_WRITE, '0, '0, 16'd100, 24'h7F_FFFF);
      send_request(OP_WRITE, '0, '0, 16'd101, 24'h80_0000);
      send_request(OP_SAMPLE, 32'h0000_0000, 32'h0000_0000, '0, '0);
      send_request(OP_SAMPLE, 32'h0000_0000, 32'h7FFF_FFFF, '0, '0);
      send_request(OP_SAMPLE, 32'h0000_0000, 32'hC000_0000, '0, '0);

      // Random phases: new settings, load what they read, then a burst of requests
      phase_index = 0;
      while (random_items < RANDOM_ITEMS) begin
         settle_block();
         no_idle = 1'b0;
         pick_settings();
         load_cycle_words();
         no_idle = ($urandom_range(0, 3) == 0);
         items = $urandom_range(20, 80);
         // long receiver stall while the sender keeps offering back to back
         if (phase_index == 2) begin
            no_idle  = 1'b1;
            hold_off = 1'b1;
         end
         for (int i = 0; i < items; i++) begin
            // pause the sender once until every sample is back
            if (phase_index == 4 && i == items / 2) begin
               settle_block();
            end
            random_request();
         end
         phase_index++;
      end

      settle_block();
      if (failures == 0) begin
         $display("wavetable_oscillator_core_tb passed");
      end else begin
         $display("wavetable_oscillator_core_tb failed");
      end
      $finish;
   end

endmodule
